[design/clim_pkg.sv]
// Shared types, constants and byte-class helpers for the case-insensitive line matcher.
// No dependencies; every other file of the block imports this package.
package clim_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int PAT_BYTES   = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_MODE     = 8'd3;

    localparam logic MODE_SUBSTRING = 1'b0;
    localparam logic MODE_NAME_LIST = 1'b1;

    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] pattern;
        logic [4:0]                length;
        logic                      mode;
    } cfg_t;

    function automatic logic [7:0] upper_of(input logic [7:0] c);
        upper_of = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic same_letter(input logic [7:0] c, input logic [7:0] d);
        same_letter = (upper_of(c) == upper_of(d));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9");
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic is_terminator(input logic [7:0] c);
        is_terminator = (c == CHAR_LPAREN) || (c == CHAR_COMMA) ||
                        (c == CHAR_TAB) || (c == CHAR_SPACE);
    endfunction

endpackage

[design/clim_cfg.sv]
// Configuration register file: pattern bytes, pattern length and match mode.
// Depends on clim_pkg for register indexes and the cfg_t bundle.
module clim_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [clim_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [clim_pkg::CFG_DATA_W-1:0]    cfg_data,
    output clim_pkg::cfg_t                     cfg
);
    import clim_pkg::*;

    logic [63:0] pat_low_reg;
    logic [63:0] pat_high_reg;
    logic [4:0]  length_reg;
    logic        mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            length_reg   <= '0;
            mode_reg     <= MODE_SUBSTRING;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                REG_PATTERN_LENGTH: length_reg   <= cfg_data[4:0];
                REG_MATCH_MODE:     mode_reg     <= cfg_data[0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.length  = length_reg;
    assign cfg.mode    = mode_reg;

endmodule

[design/clim_window.sv]
// Sliding window of the latest line bytes and the parallel substring compare.
// Depends on clim_pkg for the case-folding compare.
module clim_window #(
    parameter int P = clim_pkg::MAX_PATTERN
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fire,
    input  logic                           clear,
    input  logic [7:0]                     byte_in,
    input  logic [P-1:0][7:0]              pattern,
    input  logic [$clog2(P+1)-1:0]         eff_len,
    output logic                           hit
);
    import clim_pkg::*;

    localparam int LW  = $clog2(P + 1);
    localparam int PIW = (P > 1) ? $clog2(P) : 1;

    logic [P-1:0][7:0] recent_reg;
    logic [P-1:0][7:0] recent_next;
    logic [LW-1:0]     seen_reg;
    logic [LW-1:0]     seen_next;
    logic              all_ok;
    logic [LW-1:0]     pidx;

    always_comb begin
        recent_next[0] = byte_in;
        for (int j = 1; j < P; j++) begin
            recent_next[j] = recent_reg[j-1];
        end
        seen_next = (seen_reg == LW'(P)) ? seen_reg : seen_reg + LW'(1);

        // window slot j lines up with pattern byte len-1-j
        all_ok = 1'b1;
        pidx   = '0;
        for (int j = 0; j < P; j++) begin
            if (LW'(j) < eff_len) begin
                pidx = eff_len - LW'(1) - LW'(j);
                if (!same_letter(recent_next[j], pattern[pidx[PIW-1:0]])) begin
                    all_ok = 1'b0;
                end
            end
        end
        hit = all_ok && (seen_next >= eff_len);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= '0;
            seen_reg   <= '0;
        end else if (fire) begin
            if (clear) begin
                recent_reg <= '0;
                seen_reg   <= '0;
            end else begin
                recent_reg <= recent_next;
                seen_reg   <= seen_next;
            end
        end
    end

    a_seen_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= LW'(P))
        else $error("byte count ran past the window depth");

endmodule

[design/clim_list.sv]
// Name-list walker: compares the pattern against each entry of the leading list.
// Depends on clim_pkg for byte classes and terminator characters.
module clim_list #(
    parameter int P = clim_pkg::MAX_PATTERN
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fire,
    input  logic                           clear,
    input  logic                           enable,
    input  logic [7:0]                     byte_in,
    input  logic [P-1:0][7:0]              pattern,
    input  logic [$clog2(P+1)-1:0]         eff_len,
    output logic                           found_set
);
    import clim_pkg::*;

    localparam int LW  = $clog2(P + 1);
    localparam int PIW = (P > 1) ? $clog2(P) : 1;

    localparam logic [1:0] PH_COMPARE = 2'd0;
    localparam logic [1:0] PH_SKIP    = 2'd1;
    localparam logic [1:0] PH_BLANK   = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;
    logic [LW-1:0] idx_reg;
    logic [LW-1:0] idx_next;
    logic [1:0]    leave_phase;
    logic          do_compare;
    logic [LW-1:0] idx_base;
    logic [LW-1:0] idx_eff;

    always_comb begin
        if (is_alnum(byte_in)) begin
            leave_phase = PH_SKIP;
        end else if (byte_in == CHAR_COMMA) begin
            leave_phase = PH_BLANK;
        end else begin
            leave_phase = PH_DONE;
        end

        phase_next = phase_reg;
        idx_next   = idx_reg;
        found_set  = 1'b0;
        do_compare = 1'b0;
        idx_base   = idx_reg;

        case (phase_reg)
            PH_DONE: begin
                // hold until the line ends
            end
            PH_SKIP: begin
                phase_next = leave_phase;
            end
            PH_BLANK: begin
                if (!is_blank(byte_in)) begin
                    do_compare = 1'b1;
                    idx_base   = '0;
                    phase_next = PH_COMPARE;
                end
            end
            PH_COMPARE: begin
                do_compare = 1'b1;
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        idx_eff = (idx_base > eff_len) ? eff_len : idx_base;
        if (do_compare) begin
            idx_next = idx_eff;
            if (idx_eff < eff_len) begin
                if (same_letter(byte_in, pattern[idx_eff[PIW-1:0]])) begin
                    idx_next = idx_eff + LW'(1);
                end else begin
                    phase_next = leave_phase;
                end
            end else if (is_terminator(byte_in)) begin
                found_set  = 1'b1;
                phase_next = PH_DONE;
            end else begin
                phase_next = leave_phase;
            end
        end
        found_set = found_set && enable;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_COMPARE;
            idx_reg   <= '0;
        end else if (fire) begin
            if (clear) begin
                phase_reg <= PH_COMPARE;
                idx_reg   <= '0;
            end else if (enable) begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
            end
        end
    end

    a_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE) && fire && !clear |=> phase_reg == PH_DONE)
        else $error("name-list walker left the done phase within a line");

endmodule

[design/case_insensitive_line_matcher_top.sv]
// Top level of the case-insensitive line matcher: input register, match logic, result register.
// Depends on clim_pkg, clim_cfg, clim_window and clim_list.
//
// Usage:
//   Line bytes arrive on the s_ stream, one byte per transfer, with s_tlast
//   on the last byte of each line. One result transfer leaves on the m_
//   stream per line: m_tdata bit 0 is 1 when the line matched the pattern.
//   The cfg_ channel writes the pattern registers (index 0 pattern bytes
//   0-7, 1 bytes 8-15, 2 length, 3 mode); write it only while no line is
//   in flight. cfg_ready is always high.
//   Throughput is one byte per cycle unless a line's last byte waits for the
//   result register: the window compare across all MAX_PATTERN slots and the
//   list walker step are combinational between the input and result registers.
//   The last byte passes the input register and then the result register,
//   which raises m_tvalid. A result waiting on m_tready holds; bytes of the
//   next line keep flowing, and s_tready drops only when the next line's
//   last byte reaches the input register while the previous result is still
//   held. Reset (aresetn low, synchronous) clears the configuration to zero,
//   all per-line state and the valid flags of both stream registers.
module case_insensitive_line_matcher_top #(
    parameter int P = clim_pkg::MAX_PATTERN
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] text_byte
    input  logic                              s_tlast,   // line_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [0] matched, [7:1] zero
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [clim_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [clim_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import clim_pkg::*;

    localparam int LW = $clog2(P + 1);

    cfg_t          cfg;
    logic [LW-1:0] eff_len;

    logic          in_vld_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    logic          out_vld_reg;
    logic          out_matched_reg;
    logic          found_reg;
    logic          found_next;
    logic          fire;
    logic          win_hit;
    logic          list_found;

    clim_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign eff_len = (cfg.length > 5'(P)) ? LW'(P) : cfg.length[LW-1:0];

    // a byte that ends a line needs room in the result register
    assign fire     = in_vld_reg && (!in_last_reg || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    clim_window #(.P(P)) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .clear   (in_last_reg),
        .byte_in (in_byte_reg),
        .pattern (cfg.pattern[P-1:0]),
        .eff_len (eff_len),
        .hit     (win_hit)
    );

    clim_list #(.P(P)) u_list (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .clear     (in_last_reg),
        .enable    (cfg.mode == MODE_NAME_LIST),
        .byte_in   (in_byte_reg),
        .pattern   (cfg.pattern[P-1:0]),
        .eff_len   (eff_len),
        .found_set (list_found)
    );

    assign found_next = found_reg ||
                        ((cfg.mode == MODE_NAME_LIST) ? list_found : win_hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (fire) begin
            found_reg <= in_last_reg ? 1'b0 : found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire && in_last_reg) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_last_reg) begin
            out_matched_reg <= found_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_matched_reg};

    a_result_from_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_vld_reg || m_tready) && !(fire && in_last_reg) |=> !out_vld_reg)
        else $error("result appeared without a line end");

    a_result_value: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> out_vld_reg && (out_matched_reg == $past(found_next)))
        else $error("result register missed the finished line");

    a_found_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> !found_reg)
        else $error("match flag carried into the next line");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for case_insensitive_line_matcher_top: drives text lines on the byte
// stream and checks every per-line match flag against a built-in predictor of the matcher.
// Depends on clim_pkg and the design sources only.
module tb;
    import clim_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_OUT_OF_RANGE = 8'd4;
    localparam int LONG_STALL_CYCLES = 300;

    typedef enum logic [1:0] {
        WALK_COMPARE,
        WALK_SKIP,
        WALK_BLANK,
        WALK_DONE
    } walk_phase_t;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } text_item_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    case_insensitive_line_matcher_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register mirror, updated at each configuration transfer
    logic [7:0]  pat_bytes [MAX_PATTERN] = '{default: 8'h00};
    logic [4:0]  pat_len   = '0;
    logic        list_mode = MODE_SUBSTRING;

    // Per-line matcher state
    logic [7:0]  tail_bytes [MAX_PATTERN] = '{default: 8'h00};
    int          seen_count = 0;
    logic        line_hit   = 1'b0;
    walk_phase_t walk_phase = WALK_COMPARE;
    int          entry_pos  = 0;

    text_item_t  text_pending [$];
    text_item_t  drive_item;
    logic        match_expect [$];
    logic [7:0]  line_buf [$];
    logic        want;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int stall_requests    = 0;
    int stall_served      = 0;
    int stall_left        = 0;
    int bytes_queued      = 0;
    int bytes_accepted    = 0;
    int lines_checked     = 0;
    int lines_hit         = 0;
    int settings_applied  = 0;
    int fail_count        = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return fold_case(c) >= "A" && fold_case(c) <= "Z";
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_letter(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic logic is_space_char(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic void clear_line();
        for (int i = 0; i < MAX_PATTERN; i++) tail_bytes[i] = 8'h00;
        seen_count = 0;
        line_hit   = 1'b0;
        walk_phase = WALK_COMPARE;
        entry_pos  = 0;
    endfunction

    // A byte that does not continue the current entry
    function automatic void leave_entry(input logic [7:0] b);
        if (is_word_char(b)) walk_phase = WALK_SKIP;
        else if (b == CHAR_COMMA) walk_phase = WALK_BLANK;
        else walk_phase = WALK_DONE;
    endfunction

    function automatic void walk_list(input logic [7:0] b, input int eff);
        if (walk_phase == WALK_DONE) return;
        if (walk_phase == WALK_SKIP) begin
            leave_entry(b);
            return;
        end
        if (walk_phase == WALK_BLANK) begin
            if (is_space_char(b)) return;
            walk_phase = WALK_COMPARE;
            entry_pos  = 0;
        end
        if (entry_pos > eff) entry_pos = eff;
        if (entry_pos < eff) begin
            if (fold_case(b) == fold_case(pat_bytes[entry_pos])) entry_pos++;
            else leave_entry(b);
        end else if (b == CHAR_LPAREN || b == CHAR_COMMA || b == CHAR_TAB || b == CHAR_SPACE) begin
            line_hit   = 1'b1;
            walk_phase = WALK_DONE;
        end else begin
            leave_entry(b);
        end
    endfunction

    // Advance the predictor by one accepted byte; a line end yields one expected flag
    function automatic void scan_byte(input logic [7:0] b, input logic last);
        int   eff;
        logic hit;
        eff = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
        for (int i = MAX_PATTERN - 1; i > 0; i--) tail_bytes[i] = tail_bytes[i-1];
        tail_bytes[0] = b;
        if (seen_count < MAX_PATTERN) seen_count++;
        if (list_mode == MODE_SUBSTRING) begin
            if (seen_count >= eff) begin
                hit = 1'b1;
                for (int i = 0; i < eff; i++)
                    if (fold_case(tail_bytes[eff-1-i]) != fold_case(pat_bytes[i])) hit = 1'b0;
                if (hit) line_hit = 1'b1;
            end
        end else begin
            walk_list(b, eff);
        end
        if (last) begin
            match_expect.push_back(line_hit);
            clear_line();
        end
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(61);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + (r - 26));
        return 8'("0" + (r - 52));
    endfunction

    function automatic logic [7:0] rand_text_byte();
        if ($urandom_range(3) == 0) return 8'($urandom_range(1, 255));
        return rand_alnum();
    endfunction

    // Embed the active pattern with letters in random case
    function automatic void add_pattern_copy(input int eff);
        logic [7:0] b;
        for (int i = 0; i < eff; i++) begin
            b = pat_bytes[i];
            if (is_letter(b) && $urandom_range(1)) b = b ^ 8'h20;
            line_buf.push_back(b);
        end
    endfunction

    function automatic void queue_line();
        for (int i = 0; i < line_buf.size(); i++)
            text_pending.push_back('{text: line_buf[i], last: (i == line_buf.size() - 1)});
        bytes_queued += line_buf.size();
        line_buf.delete();
    endfunction

    function automatic void send_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
        queue_line();
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:    for (int i = 0; i < 8; i++) pat_bytes[i] = val[8*i +: 8];
            REG_PATTERN_HIGH:   for (int i = 0; i < 8; i++) pat_bytes[i+8] = val[8*i +: 8];
            REG_PATTERN_LENGTH: pat_len = val[4:0];
            REG_MATCH_MODE:     list_mode = val[0];
            default: ;
        endcase
    endtask

    task automatic config_pattern(input logic [127:0] p, input logic [4:0] len, input logic mode);
        write_reg(REG_PATTERN_LOW, p[63:0]);
        write_reg(REG_PATTERN_HIGH, p[127:64]);
        write_reg(REG_PATTERN_LENGTH, {59'd0, len});
        write_reg(REG_MATCH_MODE, {63'd0, mode});
        settings_applied++;
    endtask

    // Hold until every queued byte is accepted and every line result has come back
    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || match_expect.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (text_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                drive_item = text_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drive_item.text;
                s_tlast  <= drive_item.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result backpressure; a long stall is counted here on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_served != stall_requests) begin
            m_tready     <= 1'b0;
            stall_served <= stall_served + 1;
            stall_left   <= LONG_STALL_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (match_expect.size() == 0) begin
                    $error("matched: no result expected, got %0b", m_tdata[0]);
                    fail_count++;
                end else begin
                    want = match_expect.pop_front();
                    if (m_tdata[0] !== want) begin
                        $error("matched: expected %0b, got %0b", want, m_tdata[0]);
                        fail_count++;
                    end
                    lines_checked++;
                    if (want) lines_hit++;
                end
            end
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
        end
    end

    initial begin
        int           eff;
        int           target;
        int           entries;
        logic [4:0]   len;
        logic [127:0] rp;
        logic         mid_pause_done;

        mid_pause_done = 1'b0;
        while (!aresetn) @(posedge aclk);

        // Reset settings: empty pattern in substring mode matches anything
        send_text("a");
        wait_drained();

        // Letters fold; other bytes must be equal. The spare index must change nothing.
        config_pattern(128'h5A61, 5'd2, MODE_SUBSTRING);
        write_reg(REG_OUT_OF_RANGE, '1);
        send_text("zAz");
        line_buf.push_back(8'hFF);
        queue_line();
        wait_drained();

        // A zero pattern byte can never meet a text byte
        config_pattern(128'h0, 5'd1, MODE_SUBSTRING);
        send_text("a");
        wait_drained();

        config_pattern(128'h736C, 5'd2, MODE_NAME_LIST);
        send_text("LS,");
        send_text("x,ls\t");
        send_text("ls1");
        wait_drained();

        // Empty pattern in name-list mode: only a terminator at an entry start
        config_pattern(128'h0, 5'd0, MODE_NAME_LIST);
        send_text("(");
        send_text("a");
        wait_drained();

        // Oversized length clamps to a full 16-byte pattern
        config_pattern('1, 5'd31, MODE_SUBSTRING);
        repeat (MAX_PATTERN) line_buf.push_back(8'hFF);
        queue_line();
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            sender_idle_pct   = (ph < 4) ? 27 : (ph < 8) ? 46 : 0;
            receiver_idle_pct = (ph < 4) ? 46 : (ph < 8) ? 27 : 0;

            case ($urandom_range(9))
                0:       len = 5'd0;
                1:       len = 5'd16;
                2:       len = 5'($urandom_range(17, 31));
                default: len = 5'($urandom_range(1, 4));
            endcase
            eff = (len > MAX_PATTERN) ? MAX_PATTERN : len;
            // Used bytes stay nonzero so they can be embedded; unused ones are garbage
            for (int i = 0; i < MAX_PATTERN; i++)
                rp[8*i +: 8] = (i >= eff) ? 8'($urandom_range(255)) :
                               ($urandom_range(7) == 0) ? 8'($urandom_range(1, 255)) :
                               rand_alnum();
            config_pattern(rp, len, 1'($urandom_range(1)));

            if (ph == 2 || ph == 9) stall_requests++;

            target = bytes_queued + 170;
            while (bytes_queued < target) begin
                if (ph == 5 && !mid_pause_done && bytes_queued >= target - 85) begin
                    wait_drained();
                    mid_pause_done = 1'b1;
                end
                if ($urandom_range(5) == 0) begin
                    repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(1, 255)));
                end else if (list_mode == MODE_SUBSTRING) begin
                    repeat ($urandom_range(10)) line_buf.push_back(rand_text_byte());
                    if ($urandom_range(3) != 0) begin
                        add_pattern_copy(eff);
                        if (eff != 0 && $urandom_range(3) == 0)
                            line_buf[line_buf.size() - 1 - $urandom_range(eff - 1)] =
                                8'($urandom_range(1, 255));
                    end
                    repeat ($urandom_range(8)) line_buf.push_back(rand_text_byte());
                end else begin
                    entries = $urandom_range(1, 3);
                    for (int e = 0; e < entries; e++) begin
                        if (e > 0) begin
                            line_buf.push_back(CHAR_COMMA);
                            repeat ($urandom_range(2))
                                line_buf.push_back(($urandom_range(5) == 0) ? CHAR_SPACE :
                                                   CHAR_TAB + 8'($urandom_range(4)));
                        end
                        if ($urandom_range(1)) begin
                            add_pattern_copy(eff);
                            // near miss: one byte short or one too long
                            if ($urandom_range(3) == 0) begin
                                if (line_buf.size() != 0 && $urandom_range(1))
                                    void'(line_buf.pop_back());
                                else
                                    line_buf.push_back(rand_alnum());
                            end
                        end else begin
                            repeat ($urandom_range(1, 6)) line_buf.push_back(rand_alnum());
                        end
                    end
                    case ($urandom_range(6))
                        0:       line_buf.push_back(CHAR_LPAREN);
                        1:       line_buf.push_back(CHAR_SPACE);
                        2:       line_buf.push_back(CHAR_TAB);
                        3:       line_buf.push_back(CHAR_COMMA);
                        4:       line_buf.push_back("-");
                        5:       line_buf.push_back(rand_alnum());
                        default: line_buf.push_back(8'($urandom_range(1, 255)));
                    endcase
                    repeat ($urandom_range(8)) line_buf.push_back(rand_text_byte());
                end
                if (line_buf.size() == 0) line_buf.push_back(rand_alnum());
                queue_line();
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        $display("Checked %0d line results (%0d matches) from %0d text bytes",
                 lines_checked, lines_hit, bytes_accepted);
        $display("Pattern settings applied: %0d, both match modes, lengths 0 to 31",
                 settings_applied);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
design/clim_pkg.sv
design/clim_cfg.sv
design/clim_window.sv
design/clim_list.sv
design/case_insensitive_line_matcher_top.sv
tb/tb.sv
